// ===== src/masked_byte_pattern_scanner_assert.svh =====
// Assertion macros for the masked byte pattern scanner.
// Expects signals clk and rst_n in the scope of use.
`ifndef MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MBPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mbps_pkg.sv =====
// Shared constants and types for the masked byte pattern scanner.
// No dependencies.
package mbps_pkg;

    localparam int PATTERN_MAX   = 16;
    localparam int ADDRESS_WIDTH = 32;
    localparam int RUN_W         = $clog2(PATTERN_MAX + 1);
    localparam int PLEN_W        = 5;
    localparam int DATA_W        = 64;
    localparam int PADDR_W       = 6;

    typedef logic [ADDRESS_WIDTH-1:0] addr_t;
    typedef logic [RUN_W-1:0]         run_t;
    typedef logic [7:0]               byte_t;

    // register index, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_WILDCARD_MASK  = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_BASE_ADDRESS   = 3'd4
    } reg_idx_t;

endpackage

// ===== src/masked_byte_pattern_scanner.sv =====
// Path: an accepted request goes to the input register, then its result to the result
// register, from which it is presented. Throughput: one
// byte per cycle; the input stalls only while a result waits in the result register.
// Reset (rst_n, async, active low): scan state cleared, registers zero
// except pattern_length = 1. Depends on mbps_pkg and the assertion header.
`include "masked_byte_pattern_scanner_assert.svh"

module masked_byte_pattern_scanner (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [7:0]                  data_byte,
    input  logic                        region_ok,
    input  logic                        region_first,
    input  logic                        scan_first,
    input  logic                        scan_last,
    // result channel
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic                        found,
    output logic [31:0]                 match_address,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbps_pkg::PADDR_W-1:0] paddr,
    input  logic [mbps_pkg::DATA_W-1:0] pwdata,
    output logic [mbps_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    // configuration registers
    logic [63:0]                   pattern_low_reg;
    logic [63:0]                   pattern_high_reg;
    logic [15:0]                   wildcard_mask_reg;
    logic [mbps_pkg::PLEN_W-1:0]   pattern_length_reg;
    logic [31:0]                   base_address_reg;

    // input register
    logic                          s1_valid_reg;
    mbps_pkg::byte_t               s1_data_reg;
    logic                          s1_ok_reg;
    logic                          s1_region_first_reg;
    logic                          s1_first_reg;
    logic                          s1_last_reg;

    // scan state
    mbps_pkg::byte_t               window_reg [mbps_pkg::PATTERN_MAX];
    mbps_pkg::run_t                run_reg;
    mbps_pkg::addr_t               offset_reg;
    logic                          scan_done_reg;

    // result register
    logic                          out_valid_reg;
    logic                          found_reg;
    logic [31:0]                   match_address_reg;

    // stage logic
    logic                          adv;
    logic                          done_eff;
    mbps_pkg::byte_t               window_eff [mbps_pkg::PATTERN_MAX];
    mbps_pkg::byte_t               window_next [mbps_pkg::PATTERN_MAX];
    mbps_pkg::run_t                run_eff;
    mbps_pkg::run_t                run_base;
    mbps_pkg::run_t                run_next;
    mbps_pkg::run_t                used_len;
    mbps_pkg::addr_t               offset_eff;
    mbps_pkg::addr_t               here;
    mbps_pkg::addr_t               start_addr;
    logic [127:0]                  pattern_vec;
    logic                          window_hit;
    logic                          match;
    logic                          res_any;
    logic                          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            wildcard_mask_reg  <= '0;
            pattern_length_reg <= mbps_pkg::PLEN_W'(1);
            base_address_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[5:3])
                mbps_pkg::REG_PATTERN_LOW:    pattern_low_reg    <= pwdata;
                mbps_pkg::REG_PATTERN_HIGH:   pattern_high_reg   <= pwdata;
                mbps_pkg::REG_WILDCARD_MASK:  wildcard_mask_reg  <= pwdata[15:0];
                mbps_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= pwdata[mbps_pkg::PLEN_W-1:0];
                mbps_pkg::REG_BASE_ADDRESS:   base_address_reg   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            mbps_pkg::REG_PATTERN_LOW:    prdata = pattern_low_reg;
            mbps_pkg::REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            mbps_pkg::REG_WILDCARD_MASK:  prdata = 64'(wildcard_mask_reg);
            mbps_pkg::REG_PATTERN_LENGTH: prdata = 64'(pattern_length_reg);
            mbps_pkg::REG_BASE_ADDRESS:   prdata = 64'(base_address_reg);
            default:                      prdata = '0;
        endcase
    end

    // stage advances when the result register can take whatever it produces
    assign adv       = s1_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            s1_data_reg         <= data_byte;
            s1_ok_reg           <= region_ok;
            s1_region_first_reg <= region_first;
            s1_first_reg        <= scan_first;
            s1_last_reg         <= scan_last;
        end
    end

    assign pattern_vec = {pattern_high_reg, pattern_low_reg};

    always_comb
    begin
        if (pattern_length_reg == '0)
            used_len = mbps_pkg::run_t'(1);
        else if (pattern_length_reg > mbps_pkg::PLEN_W'(mbps_pkg::PATTERN_MAX))
            used_len = mbps_pkg::run_t'(mbps_pkg::PATTERN_MAX);
        else
            used_len = mbps_pkg::run_t'(pattern_length_reg);
    end

    // scan_first clears state before this byte is looked at
    always_comb
    begin
        done_eff   = s1_first_reg ? 1'b0 : scan_done_reg;
        run_eff    = s1_first_reg ? '0 : run_reg;
        offset_eff = s1_first_reg ? '0 : offset_reg;
        for (int k = 0; k < mbps_pkg::PATTERN_MAX; k++)
        begin
            window_eff[k] = s1_first_reg ? 8'h00 : window_reg[k];
        end
        window_next[0] = s1_data_reg;
        for (int k = 1; k < mbps_pkg::PATTERN_MAX; k++)
        begin
            window_next[k] = window_eff[k-1];
        end
    end

    always_comb
    begin
        run_base = (s1_region_first_reg || !s1_ok_reg) ? '0 : run_eff;
        if (run_base < mbps_pkg::run_t'(mbps_pkg::PATTERN_MAX))
            run_next = run_base + mbps_pkg::run_t'(1);
        else
            run_next = run_base;
    end

    // one compare set per candidate length, all at fixed window taps
    always_comb
    begin
        logic len_ok;
        window_hit = 1'b0;
        for (int l = 1; l <= mbps_pkg::PATTERN_MAX; l++)
        begin
            len_ok = 1'b1;
            for (int j = 0; j < l; j++)
            begin
                if (!wildcard_mask_reg[j] && (window_next[l-1-j] != pattern_vec[j*8 +: 8]))
                    len_ok = 1'b0;
            end
            if (used_len == mbps_pkg::run_t'(l) && len_ok)
                window_hit = 1'b1;
        end
    end

    assign here       = mbps_pkg::addr_t'(base_address_reg) + offset_eff;
    assign start_addr = here - mbps_pkg::addr_t'(used_len - mbps_pkg::run_t'(1));
    assign match      = !done_eff && s1_ok_reg && (run_next >= used_len) && window_hit;
    assign res_any    = match || (!done_eff && s1_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mbps_pkg::PATTERN_MAX; k++)
            begin
                window_reg[k] <= 8'h00;
            end
            run_reg       <= '0;
            offset_reg    <= '0;
            scan_done_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (done_eff)
            begin
                // ignored byte; the scan state is held as it is
                window_reg    <= window_eff;
                run_reg       <= run_eff;
                offset_reg    <= offset_eff;
                scan_done_reg <= done_eff;
            end
            else
            begin
                offset_reg    <= offset_eff + mbps_pkg::addr_t'(1);
                scan_done_reg <= res_any;
                if (s1_ok_reg)
                begin
                    window_reg <= window_next;
                    run_reg    <= run_next;
                end
                else
                begin
                    window_reg <= window_eff;
                    run_reg    <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && res_any)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && res_any)
        begin
            found_reg         <= match;
            match_address_reg <= match ? 32'(start_addr) : 32'd0;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = match_address_reg;

    `MBPS_ASSERT_NOW(a_notfound_zero, out_valid_reg && !found_reg, match_address_reg == 32'd0, "not-found result with nonzero address")
    `MBPS_ASSERT_NEXT(a_result_ends_scan, adv && res_any, scan_done_reg, "scan not closed after a result")
    `MBPS_ASSERT_NOW(a_done_is_quiet, adv && scan_done_reg && !s1_first_reg, !res_any, "result produced after scan end")
    `MBPS_ASSERT_NEXT(a_offset_step, adv && !done_eff, offset_reg == $past(offset_eff) + mbps_pkg::addr_t'(1), "byte offset did not advance")

endmodule
